// ===== rtl/core/spq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the stable priority task queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int ID_W     = 16;
  localparam int PRIO_W   = 2;
  localparam int MODE_W   = 2;
  localparam int STATUS_W = 3;
  localparam int LOC_W    = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_ENQ  = 2'd0,
    MODE_DEQ  = 2'd1,
    MODE_SRCH = 2'd2,
    MODE_NOP  = 2'd3
  } spq_mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_DONE_FULL = 3'd4
  } spq_status_t;

  typedef enum logic [LOC_W-1:0] {
    LOC_NONE = 2'd0,
    LOC_PEND = 2'd1,
    LOC_DONE = 2'd2
  } spq_loc_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } spq_entry_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     id;
    logic [PRIO_W-1:0]   prio;
    logic [LOC_W-1:0]    loc;
  } spq_result_t;

endpackage

// ===== rtl/core/spq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_ram
// Simple dual-port entry store: one write, one read, registered read data.
// ----------------------------------------------------------------------------
module spq_ram
  import spq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  spq_entry_t               wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output spq_entry_t               rdata
);

  spq_entry_t mem [DEPTH];
  spq_entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/spq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_ctrl
// Request sequencer: walks the pending ring and the completed store through
// their RAM ports, one entry per step.
// ----------------------------------------------------------------------------
module spq_ctrl
  import spq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int DONE_DEPTH  = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [MODE_W-1:0]               in_mode,
  input  logic [ID_W-1:0]                 in_task_id,
  input  logic [PRIO_W-1:0]               in_priority_req,
  output logic                            pend_we,
  output logic [$clog2(QUEUE_DEPTH)-1:0]  pend_waddr,
  output spq_entry_t                      pend_wdata,
  output logic [$clog2(QUEUE_DEPTH)-1:0]  pend_raddr,
  input  spq_entry_t                      pend_rdata,
  output logic                            done_we,
  output logic [$clog2(DONE_DEPTH)-1:0]   done_waddr,
  output spq_entry_t                      done_wdata,
  output logic [$clog2(DONE_DEPTH)-1:0]   done_raddr,
  input  spq_entry_t                      done_rdata,
  output logic                            res_valid,
  input  logic                            res_ready,
  output spq_result_t                     res
);

  localparam int QW  = $clog2(QUEUE_DEPTH);
  localparam int QPW = QW + 1;
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int DW  = $clog2(DONE_DEPTH);
  localparam int DCW = $clog2(DONE_DEPTH + 1);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b0_0000_0001,
    S_ENQ_RD  = 9'b0_0000_0010,
    S_ENQ_CMP = 9'b0_0000_0100,
    S_ENQ_WR  = 9'b0_0000_1000,
    S_DEQ_RD  = 9'b0_0001_0000,
    S_DEQ_WR  = 9'b0_0010_0000,
    S_SRCH_P  = 9'b0_0100_0000,
    S_SRCH_C  = 9'b0_1000_0000,
    S_FIN     = 9'b1_0000_0000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     pcount_r, pcount_nxt;
  logic [DCW-1:0]    dcount_r, dcount_nxt;
  logic [QW-1:0]     head_r, head_nxt;
  logic [CW-1:0]     p_idx_r, p_idx_nxt;
  logic [DCW-1:0]    d_idx_r, d_idx_nxt;
  logic              pend_r, pend_nxt;
  logic [ID_W-1:0]   key_r, key_nxt;
  logic [PRIO_W-1:0] prio_r, prio_nxt;
  spq_result_t       res_r, res_nxt;
  spq_entry_t        new_entry;

  // Logical queue position to physical ring slot.
  function automatic logic [QW-1:0] pphys(input logic [QW-1:0] head,
                                          input logic [QW-1:0] idx);
    logic [QPW-1:0] s;
    s = {1'b0, head} + {1'b0, idx};
    if (s >= QPW'(QUEUE_DEPTH)) begin
      s = s - QPW'(QUEUE_DEPTH);
    end
    return s[QW-1:0];
  endfunction

  assign new_entry  = '{id: key_r, prio: prio_r};
  assign in_ready   = (state_r == S_IDLE);
  assign res_valid  = (state_r == S_FIN);
  assign res        = res_r;
  assign pend_raddr = pphys(head_r, p_idx_r[QW-1:0]);
  assign done_raddr = d_idx_r[DW-1:0];
  assign done_waddr = dcount_r[DW-1:0];
  assign done_wdata = pend_rdata;

  always_comb begin
    state_nxt  = state_r;
    pcount_nxt = pcount_r;
    dcount_nxt = dcount_r;
    head_nxt   = head_r;
    p_idx_nxt  = p_idx_r;
    d_idx_nxt  = d_idx_r;
    pend_nxt   = pend_r;
    key_nxt    = key_r;
    prio_nxt   = prio_r;
    res_nxt    = res_r;
    pend_we    = 1'b0;
    pend_waddr = pphys(head_r, p_idx_r[QW-1:0] + QW'(1));
    pend_wdata = pend_rdata;
    done_we    = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          key_nxt  = in_task_id;
          prio_nxt = in_priority_req;
          res_nxt  = '{status: ST_OK, id: '0, prio: '0, loc: LOC_NONE};
          case (in_mode)
            MODE_ENQ: begin
              if (pcount_r == CW'(QUEUE_DEPTH)) begin
                res_nxt.status = ST_FULL;
                state_nxt      = S_FIN;
              end else if (pcount_r == '0) begin
                state_nxt = S_ENQ_WR;
              end else begin
                p_idx_nxt = pcount_r - CW'(1);
                state_nxt = S_ENQ_RD;
              end
            end
            MODE_DEQ: begin
              if (pcount_r == '0) begin
                res_nxt.status = ST_EMPTY;
                state_nxt      = S_FIN;
              end else begin
                p_idx_nxt = '0;
                state_nxt = S_DEQ_RD;
              end
            end
            MODE_SRCH: begin
              p_idx_nxt = '0;
              pend_nxt  = 1'b0;
              state_nxt = S_SRCH_P;
            end
            default: begin
              state_nxt = S_FIN;
            end
          endcase
        end
      end

      S_ENQ_RD: begin
        state_nxt = S_ENQ_CMP;
      end

      // Entries of lower priority move one slot back; the new task lands
      // behind the first entry of equal or higher priority.
      S_ENQ_CMP: begin
        pend_we = 1'b1;
        if (pend_rdata.prio < prio_r) begin
          if (p_idx_r == '0) begin
            state_nxt = S_ENQ_WR;
          end else begin
            p_idx_nxt = p_idx_r - CW'(1);
            state_nxt = S_ENQ_RD;
          end
        end else begin
          pend_wdata = new_entry;
          pcount_nxt = pcount_r + CW'(1);
          state_nxt  = S_FIN;
        end
      end

      S_ENQ_WR: begin
        pend_we    = 1'b1;
        pend_waddr = pphys(head_r, '0);
        pend_wdata = new_entry;
        pcount_nxt = pcount_r + CW'(1);
        state_nxt  = S_FIN;
      end

      S_DEQ_RD: begin
        state_nxt = S_DEQ_WR;
      end

      S_DEQ_WR: begin
        head_nxt     = pphys(head_r, QW'(1));
        pcount_nxt   = pcount_r - CW'(1);
        res_nxt.id   = pend_rdata.id;
        res_nxt.prio = pend_rdata.prio;
        if (dcount_r < DCW'(DONE_DEPTH)) begin
          done_we    = 1'b1;
          dcount_nxt = dcount_r + DCW'(1);
        end else begin
          res_nxt.status = ST_DONE_FULL;
        end
        state_nxt = S_FIN;
      end

      // Reads issue one per cycle; each entry is compared in the next cycle.
      S_SRCH_P: begin
        if (pend_r && pend_rdata.id == key_r) begin
          res_nxt   = '{status: ST_OK, id: pend_rdata.id, prio: pend_rdata.prio,
                        loc: LOC_PEND};
          state_nxt = S_FIN;
        end else if (p_idx_r == pcount_r) begin
          d_idx_nxt = '0;
          pend_nxt  = 1'b0;
          state_nxt = S_SRCH_C;
        end else begin
          p_idx_nxt = p_idx_r + CW'(1);
          pend_nxt  = 1'b1;
        end
      end

      S_SRCH_C: begin
        if (pend_r && done_rdata.id == key_r) begin
          res_nxt   = '{status: ST_OK, id: done_rdata.id, prio: done_rdata.prio,
                        loc: LOC_DONE};
          state_nxt = S_FIN;
        end else if (d_idx_r == dcount_r) begin
          res_nxt.status = ST_NOT_FOUND;
          state_nxt      = S_FIN;
        end else begin
          d_idx_nxt = d_idx_r + DCW'(1);
          pend_nxt  = 1'b1;
        end
      end

      S_FIN: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      pcount_r <= '0;
      dcount_r <= '0;
      head_r   <= '0;
      pend_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pcount_r <= pcount_nxt;
      dcount_r <= dcount_nxt;
      head_r   <= head_nxt;
      pend_r   <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_idx_r <= p_idx_nxt;
    d_idx_r <= d_idx_nxt;
    key_r   <= key_nxt;
    prio_r  <= prio_nxt;
    res_r   <= res_nxt;
  end

endmodule

// ===== rtl/core/stable_priority_task_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_priority_task_queue
// Bounded priority queue of tasks with a store of completed tasks.
//
// Input channel (in_valid/in_ready) carries one request per transaction:
// enqueue, dequeue or search by id. Result channel (out_valid/out_ready)
// returns exactly one transaction per request. One request is in work at a
// time; in_ready rises again as soon as the result is handed to the output
// register, so a new request may enter while the previous result waits.
// The work per request is set by the single read port of each entry RAM:
// every moved or compared entry costs one read. Ignored requests, a
// dequeue on an empty queue and an enqueue on a full one go straight to
// the result; a dequeue reads the head entry once; an enqueue reads and
// moves back each pending entry of lower priority; a search reads pending
// entries and then completed entries until it finds the id.
// Reset empties both the queue and the completed store at once; no clearing
// pass. A stalled receiver holds the result in the output register and the
// sequencer then waits with the next result until it is taken.
// ----------------------------------------------------------------------------
module stable_priority_task_queue
  import spq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int DONE_DEPTH  = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [MODE_W-1:0]   in_mode,
  input  logic [ID_W-1:0]     in_task_id,
  input  logic [PRIO_W-1:0]   in_priority_req,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] out_status,
  output logic [ID_W-1:0]     out_result_id,
  output logic [PRIO_W-1:0]   out_result_priority,
  output logic [LOC_W-1:0]    out_location
);

  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int DW = $clog2(DONE_DEPTH);

  logic          pend_we;
  logic [QW-1:0] pend_waddr, pend_raddr;
  spq_entry_t    pend_wdata, pend_rdata;
  logic          done_we;
  logic [DW-1:0] done_waddr, done_raddr;
  spq_entry_t    done_wdata, done_rdata;
  logic          res_valid, res_ready;
  spq_result_t   res;
  logic          out_valid_r, out_valid_nxt;
  spq_result_t   out_res_r;

  spq_ram #(.DEPTH(QUEUE_DEPTH)) u_pend_ram (
    .clk   (clk),
    .we    (pend_we),
    .waddr (pend_waddr),
    .wdata (pend_wdata),
    .raddr (pend_raddr),
    .rdata (pend_rdata)
  );

  spq_ram #(.DEPTH(DONE_DEPTH)) u_done_ram (
    .clk   (clk),
    .we    (done_we),
    .waddr (done_waddr),
    .wdata (done_wdata),
    .raddr (done_raddr),
    .rdata (done_rdata)
  );

  spq_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .DONE_DEPTH  (DONE_DEPTH)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_task_id      (in_task_id),
    .in_priority_req (in_priority_req),
    .pend_we         (pend_we),
    .pend_waddr      (pend_waddr),
    .pend_wdata      (pend_wdata),
    .pend_raddr      (pend_raddr),
    .pend_rdata      (pend_rdata),
    .done_we         (done_we),
    .done_waddr      (done_waddr),
    .done_wdata      (done_wdata),
    .done_raddr      (done_raddr),
    .done_rdata      (done_rdata),
    .res_valid       (res_valid),
    .res_ready       (res_ready),
    .res             (res)
  );

  // Output register
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_res_r.status;
  assign out_result_id       = out_res_r.id;
  assign out_result_priority = out_res_r.prio;
  assign out_location        = out_res_r.loc;

  // The sequencer goes busy after taking a request.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("sequencer still ready after accepting a request");

  // No result is offered while the sequencer is waiting for a request.
  a_no_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !res_valid)
    else $error("result offered while idle");

  // A result handed over always shows up on the output.
  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_ready) |=> out_valid)
    else $error("handed-over result not visible on output");

endmodule

// ===== test/tb_stable_priority_task_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stable_priority_task_queue
// Self-checking bench for the stable priority task queue. Drives enqueue,
// dequeue, search and unused requests through the valid/ready input channel.
// A shadow of the pending queue and completed store predicts every reply,
// which is compared field by field in arrival order. The run passes through
// phases of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module tb_stable_priority_task_queue
  import spq_pkg::*;
();

  localparam int QDEPTH     = 16;
  localparam int DDEPTH     = 256;
  localparam int PHASE_REQS = 256;
  localparam int TAIL_WAIT  = 300;
  localparam int LIMIT      = 2000000;

  class task_queue_model;
    spq_entry_t  pend [QDEPTH];
    int          pend_cnt;
    spq_entry_t  done_store [DDEPTH];
    int          done_cnt;
    spq_result_t pending_replies [$];
    int          errors;

    function new();
      pend_cnt = 0;
      done_cnt = 0;
      errors   = 0;
    endfunction

    function void log_request(spq_mode_t mode, logic [ID_W-1:0] id,
                              logic [PRIO_W-1:0] prio);
      spq_result_t r;
      int pos;
      bit hit;
      r   = '0;
      hit = 1'b0;
      case (mode)
        MODE_ENQ: begin
          if (pend_cnt >= QDEPTH) begin
            r.status = ST_FULL;
          end else begin
            pos = 0;
            // equal priority stays ahead: first in, first out per level
            while (pos < pend_cnt && pend[pos].prio >= prio) pos++;
            for (int i = pend_cnt; i > pos; i--) pend[i] = pend[i-1];
            pend[pos].id   = id;
            pend[pos].prio = prio;
            pend_cnt++;
            r.status = ST_OK;
          end
        end
        MODE_DEQ: begin
          if (pend_cnt == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.id   = pend[0].id;
            r.prio = pend[0].prio;
            for (int i = 1; i < pend_cnt; i++) pend[i-1] = pend[i];
            pend_cnt--;
            if (done_cnt < DDEPTH) begin
              done_store[done_cnt] = '{id: r.id, prio: r.prio};
              done_cnt++;
              r.status = ST_OK;
            end else begin
              r.status = ST_DONE_FULL;
            end
            r.loc = LOC_NONE;
          end
        end
        MODE_SRCH: begin
          for (int i = 0; i < pend_cnt && !hit; i++) begin
            if (pend[i].id == id) begin
              r   = '{status: ST_OK, id: pend[i].id, prio: pend[i].prio, loc: LOC_PEND};
              hit = 1'b1;
            end
          end
          for (int i = 0; i < done_cnt && !hit; i++) begin
            if (done_store[i].id == id) begin
              r = '{status: ST_OK, id: done_store[i].id, prio: done_store[i].prio,
                    loc: LOC_DONE};
              hit = 1'b1;
            end
          end
          if (!hit) r.status = ST_NOT_FOUND;
        end
        default: r.status = ST_OK;
      endcase
      pending_replies.push_back(r);
    endfunction

    function void check_reply(spq_result_t got);
      spq_result_t exp;
      if (pending_replies.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected reply st=%0d id=%h pr=%0d loc=%0d",
                   $realtime, got.status, got.id, got.prio, got.loc);
        return;
      end
      exp = pending_replies.pop_front();
      if (got.status !== exp.status || got.id !== exp.id ||
          got.prio !== exp.prio || got.loc !== exp.loc) begin
        errors++;
        if (errors <= 10)
          $display("%0t: reply st=%0d id=%h pr=%0d loc=%0d, exp st=%0d id=%h pr=%0d loc=%0d",
                   $realtime, got.status, got.id, got.prio, got.loc,
                   exp.status, exp.id, exp.prio, exp.loc);
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [MODE_W-1:0] in_mode;
  logic [ID_W-1:0]   in_task_id;
  logic [PRIO_W-1:0] in_priority_req;
  logic              out_valid;
  logic              out_ready;
  logic [STATUS_W-1:0] out_status;
  logic [ID_W-1:0]     out_result_id;
  logic [PRIO_W-1:0]   out_result_priority;
  logic [LOC_W-1:0]    out_location;

  task_queue_model   shadow;
  logic [ID_W-1:0]   id_hist [$];
  int                send_idle_pct;
  int                recv_stall_pct;
  int                cycles;

  stable_priority_task_queue #(
    .QUEUE_DEPTH(QDEPTH),
    .DONE_DEPTH (DDEPTH)
  ) uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_mode            (in_mode),
    .in_task_id         (in_task_id),
    .in_priority_req    (in_priority_req),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_result_id      (out_result_id),
    .out_result_priority(out_result_priority),
    .out_location       (out_location)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      shadow.check_reply('{status: out_status, id: out_result_id,
                           prio: out_result_priority, loc: out_location});
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("stable_priority_task_queue: mismatch");
      $finish;
    end
  end

  // Called and returning at a falling edge; one transaction per call.
  task automatic send_request(spq_mode_t mode, logic [ID_W-1:0] id,
                              logic [PRIO_W-1:0] prio);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_mode         <= mode;
    in_task_id      <= id;
    in_priority_req <= prio;
    do @(posedge clk); while (!in_ready);
    shadow.log_request(mode, id, prio);
    if (mode == MODE_ENQ) begin
      id_hist.push_back(id);
      if (id_hist.size() > 64) void'(id_hist.pop_front());
    end
    @(negedge clk);
  endtask

  function automatic logic [ID_W-1:0] pick_task_id(int reuse_pct);
    if (id_hist.size() != 0 && $urandom_range(0, 99) < reuse_pct)
      return id_hist[$urandom_range(0, id_hist.size() - 1)];
    return ID_W'($urandom_range(0, 65535));
  endfunction

  task automatic random_requests(int n);
    int done_reqs;
    int pick;
    int burst;
    done_reqs = 0;
    while (done_reqs < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        // fill past the top to hit the full queue
        burst = $urandom_range(14, 20);
        repeat (burst) send_request(MODE_ENQ, pick_task_id(30),
                                    PRIO_W'($urandom_range(0, 3)));
        done_reqs += burst;
      end else if (pick < 20) begin
        burst = $urandom_range(14, 20);
        repeat (burst) send_request(MODE_DEQ, ID_W'($urandom_range(0, 65535)),
                                    PRIO_W'($urandom_range(0, 3)));
        done_reqs += burst;
      end else if (pick < 25) begin
        send_request(MODE_NOP, ID_W'($urandom_range(0, 65535)),
                     PRIO_W'($urandom_range(0, 3)));
      end else if (pick < 55) begin
        send_request(MODE_ENQ, pick_task_id(30), PRIO_W'($urandom_range(0, 3)));
        done_reqs++;
      end else if (pick < 80) begin
        send_request(MODE_DEQ, ID_W'($urandom_range(0, 65535)),
                     PRIO_W'($urandom_range(0, 3)));
        done_reqs++;
      end else begin
        send_request(MODE_SRCH, pick_task_id(70), PRIO_W'($urandom_range(0, 3)));
        done_reqs++;
      end
    end
  endtask

  initial begin
    shadow          = new();
    cycles          = 0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_mode         = MODE_NOP;
    in_task_id      = '0;
    in_priority_req = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty cases, unused mode, extremes, ordering within a level
    send_request(MODE_DEQ,  16'h0000, 2'd0);
    send_request(MODE_SRCH, 16'h0000, 2'd0);
    send_request(MODE_NOP,  16'hFFFF, 2'd3);
    send_request(MODE_ENQ,  16'h0000, 2'd0);
    send_request(MODE_ENQ,  16'hFFFF, 2'd3);
    send_request(MODE_ENQ,  16'h1234, 2'd3);
    send_request(MODE_SRCH, 16'hFFFF, 2'd0);
    send_request(MODE_DEQ,  16'h0000, 2'd0);
    send_request(MODE_SRCH, 16'hFFFF, 2'd3);
    send_request(MODE_SRCH, 16'h5555, 2'd0);
    repeat (14) send_request(MODE_ENQ, ID_W'($urandom_range(0, 65535)),
                             PRIO_W'($urandom_range(0, 3)));
    send_request(MODE_ENQ, 16'hA5A5, 2'd2);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      random_requests(PHASE_REQS);
    end
    in_valid <= 1'b0;

    while (shadow.pending_replies.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
    if (shadow.errors == 0)
      $display("stable_priority_task_queue: match");
    else
      $display("stable_priority_task_queue: mismatch");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/spq_pkg.sv
rtl/core/spq_ram.sv
rtl/core/spq_ctrl.sv
rtl/core/stable_priority_task_queue.sv
test/tb_stable_priority_task_queue.sv
